/* rtl/core/sbfb_pkg.sv */
// Package for the sparse block framebuffer: geometry constants, widths,
// command codes and the command record passed from front to back.
// No dependencies.
`default_nettype none

package sbfb_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 600;
  localparam int TILE_WIDTH    = 20;
  localparam int TILE_HEIGHT   = 20;
  localparam int POOL_SIZE     = 40;

  localparam int TILES_X     = SCREEN_WIDTH / TILE_WIDTH;
  localparam int TILES_Y     = SCREEN_HEIGHT / TILE_HEIGHT;
  localparam int TILE_BYTES  = (TILE_WIDTH + 3) / 4;
  localparam int BUF_BYTES   = TILE_HEIGHT * TILE_BYTES;
  localparam int NUM_TILES   = TILES_X * TILES_Y;
  localparam int STORE_DEPTH = POOL_SIZE * BUF_BYTES;

  localparam int SLOT_W   = $clog2(NUM_TILES);
  localparam int MAP_W    = $clog2(POOL_SIZE + 1);
  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int OFF_W    = $clog2(BUF_BYTES);
  localparam int TY_W     = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
  localparam int COORD_W  = 10;
  localparam int REM_W    = 6;

  // Reciprocals for exact division of values below 1024 by divisors up to 64.
  localparam int RECIP_SH = 17;
  localparam int RECIP_W  = 18;
  localparam int PROD_W   = COORD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TW =
    RECIP_W'(((1 << RECIP_SH) + TILE_WIDTH - 1) / TILE_WIDTH);
  localparam logic [RECIP_W-1:0] RECIP_TB =
    RECIP_W'(((1 << RECIP_SH) + TILE_BYTES - 1) / TILE_BYTES);
  localparam logic [RECIP_W-1:0] RECIP_TH =
    RECIP_W'(((1 << RECIP_SH) + TILE_HEIGHT - 1) / TILE_HEIGHT);

  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] CODE_WHITE = 2'd2;
  localparam logic [1:0] CODE_BLACK = 2'd1;

  typedef enum logic [1:0] {OP_DRAW, OP_READ, OP_CLEAR, OP_SKIP} op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [TY_W-1:0]   ty;
    logic [OFF_W-1:0]  off;
    logic [1:0]        pix;
    logic              color;
  } cmd_t;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_DIV, F_ADDR, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CLEAR, B_MAP, B_BASE, B_ZERO, B_ADDR, B_DATA
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/core/sbfb_front.sv */
// Front end: takes commands, splits coordinates into tile and offset, and
// pushes one command record into the queue. Depends on sbfb_pkg.
`default_nettype none

module sbfb_front import sbfb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    front_busy,
  input  wire logic [1:0]         mode,
  input  wire logic [COORD_W-1:0] pixel_x,
  input  wire logic [COORD_W-1:0] pixel_y,
  input  wire logic               color,
  input  wire logic [7:0]         byte_column,
  input  wire logic               q_full,
  output logic                    q_push,
  output cmd_t                    q_data
);

  front_state_t state, state_next;

  logic [1:0]         mode_r;
  logic               color_r;
  logic [COORD_W-1:0] hx, vy;
  logic [PROD_W-1:0]  prod_h, prod_v;
  logic [COORD_W-1:0] qh, qv;
  logic [REM_W-1:0]   rh, rv;
  cmd_t               cmd;

  logic               is_draw;
  logic [COORD_W-1:0] qh_w, qv_w;
  logic [OFF_W-1:0]   byte_in_row;
  logic               outside;

  assign is_draw    = (mode_r == MODE_DRAW);
  assign qh_w       = prod_h[RECIP_SH +: COORD_W];
  assign qv_w       = prod_v[RECIP_SH +: COORD_W];
  assign outside    = (qv >= COORD_W'(TILES_Y)) || (qh >= COORD_W'(TILES_X));
  assign byte_in_row = is_draw ? OFF_W'(rh >> 2) : OFF_W'(rh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    front_busy = (state != F_IDLE);
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (start) begin
          state_next = (mode == MODE_DRAW || mode == MODE_READ) ? F_MUL : F_PUSH;
        end
      end
      F_MUL:  state_next = F_DIV;
      F_DIV:  state_next = F_ADDR;
      F_ADDR: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      mode_r    <= mode;
      color_r   <= color;
      hx        <= (mode == MODE_DRAW) ? pixel_x : COORD_W'(byte_column);
      vy        <= pixel_y;
      cmd.op    <= (mode == MODE_CLEAR) ? OP_CLEAR : OP_SKIP;
      cmd.slot  <= '0;
      cmd.ty    <= '0;
      cmd.off   <= '0;
      cmd.pix   <= '0;
      cmd.color <= color;
    end
    if (state == F_MUL) begin
      prod_h <= hx * (is_draw ? RECIP_TW : RECIP_TB);
      prod_v <= vy * RECIP_TH;
    end
    if (state == F_DIV) begin
      qh <= qh_w;
      qv <= qv_w;
      rh <= REM_W'(hx - COORD_W'(qh_w * (is_draw ? TILE_WIDTH : TILE_BYTES)));
      rv <= REM_W'(vy - COORD_W'(qv_w * TILE_HEIGHT));
    end
    if (state == F_ADDR) begin
      cmd.op    <= outside ? OP_SKIP : (is_draw ? OP_DRAW : OP_READ);
      cmd.slot  <= SLOT_W'(qv * TILES_X + qh);
      cmd.ty    <= TY_W'(qv);
      cmd.off   <= OFF_W'(rv * TILE_BYTES + byte_in_row);
      cmd.pix   <= rh[1:0];
      cmd.color <= color_r;
    end
  end

  assign q_data = cmd;

endmodule

`default_nettype wire

/* rtl/core/sbfb_queue.sv */
// Two-entry command queue between front and back ends.
// Depends on sbfb_pkg.
`default_nettype none

module sbfb_queue import sbfb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      full,
  output logic      empty
);

  cmd_t       slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

endmodule

`default_nettype wire

/* rtl/core/sbfb_back.sv */
// Back end: tile map, buffer pool allocation, pixel read-modify-write and
// scan reads; produces one result per command. Depends on sbfb_pkg.
`default_nettype none

module sbfb_back import sbfb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        clearing,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [7:0]  scan_byte,
  output logic        row_has_blocks
);

  back_state_t state, state_next;

  logic [MAP_W-1:0]    tile_map [NUM_TILES];
  logic [7:0]          store    [STORE_DEPTH];

  cmd_t                cur;
  logic [SLOT_W-1:0]   clr_cnt;
  logic                clr_report;
  logic [MAP_W-1:0]    next_free;
  logic [TILES_Y-1:0]  row_has;
  logic [MAP_W-1:0]    map_q;
  logic [MAP_W-1:0]    buf_idx;
  logic                alloc;
  logic [STORE_AW-1:0] base, addr;
  logic [OFF_W-1:0]    zcnt;
  logic [7:0]          store_q;

  logic                emit;
  logic [1:0]          e_status;
  logic [7:0]          e_byte;
  logic                e_has;
  logic                take_buf;
  logic [2:0]          sh;
  logic [7:0]          new_byte;

  assign clearing = (state == B_CLEAR);
  assign take_buf = (map_q == '0) && (cur.op == OP_DRAW)
                    && (next_free < MAP_W'(POOL_SIZE));
  assign sh       = {~cur.pix, 1'b0};
  assign new_byte = (store_q & ~(8'd3 << sh))
                    | (8'(cur.color ? CODE_WHITE : CODE_BLACK) << sh);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    e_status   = ST_DONE;
    e_byte     = 8'd0;
    e_has      = 1'b0;
    unique case (state)
      B_CLEAR: begin
        if (clr_cnt == SLOT_W'(NUM_TILES - 1)) begin
          state_next = B_IDLE;
          emit       = clr_report;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_data.op)
            OP_SKIP: begin
              emit     = 1'b1;
              e_status = ST_IGNORED;
            end
            OP_CLEAR: state_next = B_CLEAR;
            default:  state_next = B_MAP;
          endcase
        end
      end
      B_MAP: begin
        if (map_q == '0 && cur.op == OP_READ) begin
          emit       = 1'b1;
          e_has      = row_has[cur.ty];
          state_next = B_IDLE;
        end else if (map_q == '0 && !take_buf) begin
          // pool exhausted: refuse the write
          emit       = 1'b1;
          e_status   = ST_FULL;
          state_next = B_IDLE;
        end else begin
          state_next = B_BASE;
        end
      end
      B_BASE: state_next = alloc ? B_ZERO : B_ADDR;
      B_ZERO: begin
        if (zcnt == OFF_W'(BUF_BYTES - 1)) state_next = B_ADDR;
      end
      B_ADDR: state_next = B_DATA;
      B_DATA: begin
        emit       = 1'b1;
        state_next = B_IDLE;
        if (cur.op == OP_READ) begin
          e_byte = store_q;
          e_has  = row_has[cur.ty];
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      next_free  <= '0;
      row_has    <= '0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (state == B_IDLE && q_pop && q_data.op == OP_CLEAR) begin
        clr_cnt    <= '0;
        clr_report <= 1'b1;
        next_free  <= '0;
        row_has    <= '0;
      end
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (state_next == B_IDLE) clr_report <= 1'b0;
      end
      if (state == B_MAP && take_buf) begin
        next_free           <= next_free + 1'b1;
        row_has[cur.ty]     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    status         <= e_status;
    scan_byte      <= e_byte;
    row_has_blocks <= e_has;
    if (state == B_IDLE && q_pop) begin
      cur   <= q_data;
      map_q <= tile_map[q_data.slot];
    end
    if (state == B_CLEAR) tile_map[clr_cnt] <= '0;
    if (state == B_MAP) begin
      alloc <= take_buf;
      if (take_buf) begin
        tile_map[cur.slot] <= next_free + 1'b1;
        buf_idx            <= next_free;
      end else begin
        buf_idx <= map_q - 1'b1;
      end
    end
    if (state == B_BASE) begin
      base <= STORE_AW'(buf_idx * BUF_BYTES);
      zcnt <= '0;
    end
    if (state == B_ZERO) begin
      // zero the fresh buffer one byte a cycle
      store[base + STORE_AW'(zcnt)] <= 8'd0;
      zcnt <= zcnt + 1'b1;
    end
    if (state == B_ADDR) begin
      addr    <= base + STORE_AW'(cur.off);
      store_q <= store[base + STORE_AW'(cur.off)];
    end
    if (state == B_DATA && cur.op == OP_DRAW) store[addr] <= new_byte;
  end

endmodule

`default_nettype wire

/* rtl/core/sparse_block_framebuffer.sv */
// Sparse tiled framebuffer for a 2-bit-per-pixel e-ink panel: pixel draw,
// scan byte read and map clear. After reset, and after every clear command,
// the tile map is swept one entry a cycle while busy is high; a clear reports
// its result at the end of that sweep. A draw or read holds busy after it is
// accepted through the multiply, divide, address and push steps, and longer
// while the queue is full; a clear or unused mode goes straight to the push
// step. The back end reports an out-of-range command from its idle state, a
// read of an unallocated tile or a refused write from its map state, and a
// read or draw that touches the store from its data state, after its map,
// base and address states. A draw that allocates a new tile buffer first
// zeroes it through the single store port. Outside a map sweep, the front end
// accepts the next command while the back end works, held by a two-entry queue.
// Each result is shown for one cycle with strobe; the receiver cannot stall.
// Depends on sbfb_pkg, sbfb_front, sbfb_queue and sbfb_back.
`default_nettype none

module sparse_block_framebuffer import sbfb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [COORD_W-1:0] pixel_x,
  input  wire logic [COORD_W-1:0] pixel_y,
  input  wire logic               color,
  input  wire logic [7:0]         byte_column,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic [7:0]              scan_byte,
  output logic                    row_has_blocks
);

  logic front_busy, clearing;
  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_data, pop_data;

  assign busy = front_busy | clearing;

  sbfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start & ~clearing),
    .front_busy  (front_busy),
    .mode        (mode),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .color       (color),
    .byte_column (byte_column),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  sbfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sbfb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .strobe         (strobe),
    .status         (status),
    .scan_byte      (scan_byte),
    .row_has_blocks (row_has_blocks)
  );

endmodule

`default_nettype wire
